[rtl/core/dtps_pkg.sv]
// types, constants and the gain table builder for the dual-tap pitch shifter
// no dependencies
package dtps_pkg;

  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned RATIO_W   = 15;
  localparam int unsigned DELAY_W   = 28;
  localparam int unsigned COEFF_W   = 16;
  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned SMOOTH_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP = 2'd3;

  localparam logic [DELAY_W-1:0] MIN_DELAY_RST = 28'd65536;
  localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 28'd67108864;
  localparam logic [COEFF_W-1:0] SMOOTH_RST    = 16'd655;
  localparam logic [COEFF_W-1:0] FADE_STEP_RST = 16'd256;

  localparam logic [RATIO_W-1:0] RATIO_MIN   = 15'd1024;
  localparam logic [RATIO_W-1:0] RATIO_MAX   = 15'd16384;
  localparam logic [RATIO_W-1:0] RATIO_UNITY = 15'd4096;
  localparam longint UNITY_Q28  = 64'sd268435456;
  localparam longint UNITY_TOL  = 64'sd26843;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_SMUL, S_SUPD, S_WR, S_RA1, S_RB1, S_RA2, S_RB2, S_RW,
    S_I1, S_I2, S_I3, S_G1, S_G2, S_G3, S_UPD, S_FADE, S_OUT
  } dtps_state_t;

  // quarter-sine entry from the scaled angle y (Q30), taylor series to y^13
  function automatic logic [GAIN_W-1:0] gain_from_y(input longint unsigned y);
    longint unsigned t;
    longint          acc;
    longint          v;
    t   = y;
    acc = longint'(y);
    t = (t * y) >> 30; t = (t * y) >> 30; t = t / 6;   acc = acc - longint'(t);
    t = (t * y) >> 30; t = (t * y) >> 30; t = t / 20;  acc = acc + longint'(t);
    t = (t * y) >> 30; t = (t * y) >> 30; t = t / 42;  acc = acc - longint'(t);
    t = (t * y) >> 30; t = (t * y) >> 30; t = t / 72;  acc = acc + longint'(t);
    t = (t * y) >> 30; t = (t * y) >> 30; t = t / 110; acc = acc - longint'(t);
    t = (t * y) >> 30; t = (t * y) >> 30; t = t / 156; acc = acc + longint'(t);
    if (acc < 0) acc = 0;
    v = (acc + 16384) >>> 15;
    if (v > 32768) v = 32768;
    return GAIN_W'(v);
  endfunction

endpackage

[rtl/core/dtps_gain_rom.sv]
// quarter-sine gain table with two combinational read ports
// depends on dtps_pkg
module dtps_gain_rom #(
  parameter int GAIN_TABLE_DEPTH = 256
) (
  input  logic [$clog2(GAIN_TABLE_DEPTH+1)-1:0] idx_a,
  input  logic [$clog2(GAIN_TABLE_DEPTH+1)-1:0] idx_b,
  output logic [dtps_pkg::GAIN_W-1:0]           gain_a,
  output logic [dtps_pkg::GAIN_W-1:0]           gain_b
);
  import dtps_pkg::*;

  logic [GAIN_W-1:0] rom [0:GAIN_TABLE_DEPTH];

  for (genvar g = 0; g <= GAIN_TABLE_DEPTH; g++) begin : g_rom
    localparam longint unsigned Y =
      (longint'(g) * HALF_PI_Q30) / GAIN_TABLE_DEPTH;
    assign rom[g] = gain_from_y(Y);
  end

  assign gain_a = (int'(idx_a) > GAIN_TABLE_DEPTH) ? '0 : rom[idx_a];
  assign gain_b = (int'(idx_b) > GAIN_TABLE_DEPTH) ? '0 : rom[idx_b];

endmodule

[rtl/core/dual_tap_delay_pitch_shifter_top.sv]
// dual-tap delay-line pitch shifter, top level
// depends on dtps_pkg and dtps_gain_rom
// flow: a unity pass-through request goes from S_CHK straight to S_OUT; any other request first
//   runs the ratio filter update (skipped for the request that seeds it), the delay-line write and
//   reads, interpolation, gains and tap update; a new request waits until the last result is
//   loaded for output; the four delay-line reads share one read port, and five steps one multiplier
// reset: rst_n synchronous active low; config to defaults; ratio filter, taps and fade clear;
//   delay-line words never written read as zero through a fill mark, no clearing pass
module dual_tap_delay_pitch_shifter_top #(
  parameter int BUFFER_DEPTH     = 4096,
  parameter int GAIN_TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample_in [23:0], pitch_ratio [38:24], zero pad [39]
  input  logic [dtps_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample_out [23:0]
  output logic [dtps_pkg::SAMPLE_W-1:0]     out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic [dtps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dtps_pkg::DELAY_W-1:0]      cfg_wdata
);
  import dtps_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = AW + 16;
  localparam int XW = (PW > 28) ? PW : 28;
  localparam int GW = $clog2(GAIN_TABLE_DEPTH + 1);
  localparam int KW = 16 + GW;

  // configuration registers
  logic [DELAY_W-1:0] min_delay_r, max_delay_r;
  logic [COEFF_W-1:0] smooth_coeff_r, fade_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_delay_r    <= MIN_DELAY_RST;
      max_delay_r    <= MAX_DELAY_RST;
      smooth_coeff_r <= SMOOTH_RST;
      fade_step_r    <= FADE_STEP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MIN_DELAY: min_delay_r    <= cfg_wdata;
        REG_MAX_DELAY: max_delay_r    <= cfg_wdata;
        REG_SMOOTH:    smooth_coeff_r <= cfg_wdata[COEFF_W-1:0];
        REG_FADE_STEP: fade_step_r    <= cfg_wdata[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  dtps_state_t state_r, state_nxt;
  logic                out_valid_r;
  logic [AW-1:0]       wr_idx_r;
  logic                full_r;      // delay line has wrapped once
  logic                ratio_valid_r;
  logic [SMOOTH_W-1:0] smooth_r;
  logic [DELAY_W-1:0]  tap1_dly_r, tap2_dly_r;
  logic [15:0]         fade_phase_r;
  logic                fading_r;

  // per-request payload
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [RATIO_W-1:0]         ratio_r;
  logic signed [SAMPLE_W-1:0] a1_r, b1_r, a2_r, b2_r;
  logic signed [SAMPLE_W-1:0] tap1_r, tap2_r;
  logic signed [50:0]         mul_r, acc_r;
  logic signed [SAMPLE_W-1:0] res_r, out_data_r;
  logic signed [30:0]         t1n_r, t2n_r;

  // delay line
  logic [SAMPLE_W-1:0] mem [0:BUFFER_DEPTH-1];
  logic [SAMPLE_W-1:0] rd_q;
  logic                rd_ok_r;
  logic                mem_we;
  logic [AW-1:0]       rd_addr;
  logic                rd_ok;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx_r] <= sample_r;
    rd_q    <= mem[rd_addr];
    rd_ok_r <= rd_ok;
  end

  logic signed [SAMPLE_W-1:0] rd_val;
  assign rd_val = rd_ok_r ? $signed(rd_q) : '0;

  // read positions of both taps
  logic [XW-1:0] wpos, pos1_full, pos2_full;
  logic [PW-1:0] pos1, pos2;
  logic [AW-1:0] i0_1, i1_1, i0_2, i1_2;
  assign wpos      = XW'({wr_idx_r, 16'b0});
  assign pos1_full = wpos - XW'(tap1_dly_r);
  assign pos2_full = wpos - XW'(tap2_dly_r);
  assign pos1 = pos1_full[PW-1:0];
  assign pos2 = pos2_full[PW-1:0];
  assign i0_1 = pos1[PW-1:16];
  assign i1_1 = i0_1 + 1'b1;
  assign i0_2 = pos2[PW-1:16];
  assign i1_2 = i0_2 + 1'b1;

  // crossfade gains
  logic [KW-1:0]     kprod;
  logic [GW-1:0]     k_idx, k_inv;
  logic [GAIN_W-1:0] gain1, gain2;
  assign kprod = KW'(fade_phase_r) * KW'(GAIN_TABLE_DEPTH);
  assign k_idx = (int'(kprod[KW-1:16]) >= GAIN_TABLE_DEPTH) ?
                 GW'(GAIN_TABLE_DEPTH - 1) : kprod[KW-1:16];
  assign k_inv = GW'(GAIN_TABLE_DEPTH) - k_idx;

  dtps_gain_rom #(.GAIN_TABLE_DEPTH(GAIN_TABLE_DEPTH)) u_gain_rom (
    .idx_a  (k_inv),
    .idx_b  (k_idx),
    .gain_a (gain1),
    .gain_b (gain2)
  );

  // shared multiplier operands
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [32:0] target_s, smooth_s;
  assign target_s = $signed({2'b0, ratio_r, 16'b0});
  assign smooth_s = $signed({1'b0, smooth_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SMUL: begin
        mul_a = target_s - smooth_s;
        mul_b = $signed({2'b0, smooth_coeff_r});
      end
      S_I1: begin
        mul_a = 33'($signed({b1_r[23], b1_r}) - $signed({a1_r[23], a1_r}));
        mul_b = $signed({2'b0, pos1[15:0]});
      end
      S_I2: begin
        mul_a = 33'($signed({b2_r[23], b2_r}) - $signed({a2_r[23], a2_r}));
        mul_b = $signed({2'b0, pos2[15:0]});
      end
      S_G1: begin
        mul_a = 33'(tap1_r);
        mul_b = $signed({1'b0, gain1});
      end
      S_G2: begin
        mul_a = 33'(tap2_r);
        mul_b = $signed({1'b0, gain2});
      end
      default: ;
    endcase
  end

  // unity pass-through test
  logic signed [32:0] dev;
  logic               pass;
  assign dev  = smooth_s - 33'(UNITY_Q28);
  assign pass = (ratio_r == RATIO_UNITY) &&
                (!ratio_valid_r || (dev >= -33'(UNITY_TOL) && dev <= 33'(UNITY_TOL)));

  // rounding of the multiplier result
  logic signed [51:0] smooth_sum, interp_sum, mix_sum;
  logic signed [32:0] smooth_new;
  logic signed [SAMPLE_W-1:0] interp_tap;
  logic signed [36:0] mix_rnd;
  logic signed [SAMPLE_W-1:0] mix_sat;
  logic signed [SAMPLE_W-1:0] a_sel;

  assign a_sel      = (state_r == S_I2) ? a1_r : a2_r;
  assign smooth_sum = 52'(mul_r) + 52'sd32768;
  assign smooth_new = smooth_s + smooth_sum[48:16];
  assign interp_sum = $signed({{12{a_sel[23]}}, a_sel, 16'b0}) + 52'(mul_r) + 52'sd32768;
  assign interp_tap = interp_sum[39:16];
  assign mix_sum    = 52'(acc_r) + 52'(mul_r) + 52'sd16384;
  assign mix_rnd    = mix_sum[51:15];
  assign mix_sat    = (mix_rnd > 37'sd8388607)  ? 24'sh7FFFFF :
                      (mix_rnd < -37'sd8388608) ? 24'sh800000 : mix_rnd[23:0];

  // delay move and crossfade control
  logic signed [32:0] dc;
  logic signed [32:0] dc_rnd;
  logic signed [30:0] step16;
  logic signed [30:0] min_s, max_s, thr_s;
  assign dc     = 33'(UNITY_Q28) - smooth_s;
  assign dc_rnd = (dc + 33'sd2048) >>> 12;
  assign step16 = dc_rnd[30:0];
  assign min_s  = $signed({3'b0, min_delay_r});
  assign max_s  = $signed({3'b0, max_delay_r});
  assign thr_s  = $signed({5'b0, max_delay_r[DELAY_W-1:2]});

  logic               trig, fade_on, fade_end;
  logic [16:0]        phase_sum;
  logic signed [30:0] t1_sel, t2_sel, t2_trig;
  logic [DELAY_W-1:0] t1_clamp, t2_clamp;

  function automatic logic [DELAY_W-1:0] clamp_dly(input logic signed [30:0] d,
                                                   input logic signed [30:0] lo,
                                                   input logic signed [30:0] hi);
    logic signed [30:0] v;
    v = d;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v[DELAY_W-1:0];
  endfunction

  always_comb begin
    trig = !fading_r &&
           ((dc < 0 && t1n_r <= min_s + thr_s) || (dc > 0 && t1n_r >= max_s - thr_s));
    t2_trig   = trig ? ((dc < 0) ? max_s : min_s) : t2n_r;
    fade_on   = fading_r || trig;
    phase_sum = {1'b0, fade_phase_r} + {1'b0, fade_step_r};
    fade_end  = fade_on && phase_sum[16];
    t1_sel    = fade_end ? t2_trig : t1n_r;
    t2_sel    = fade_end ? t1n_r : t2_trig;
    t1_clamp  = clamp_dly(t1_sel, min_s, max_s);
    t2_clamp  = clamp_dly(t2_sel, min_s, max_s);
  end

  // next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = i0_1;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = S_CHK;
      end
      S_CHK: begin
        priority if (pass)       state_nxt = S_OUT;
        else if (!ratio_valid_r) state_nxt = S_WR;
        else                     state_nxt = S_SMUL;
      end
      S_SMUL: state_nxt = S_SUPD;
      S_SUPD: state_nxt = S_WR;
      S_WR: begin
        mem_we    = 1'b1;
        state_nxt = S_RA1;
      end
      S_RA1: begin rd_addr = i0_1; state_nxt = S_RB1; end
      S_RB1: begin rd_addr = i1_1; state_nxt = S_RA2; end
      S_RA2: begin rd_addr = i0_2; state_nxt = S_RB2; end
      S_RB2: begin rd_addr = i1_2; state_nxt = S_RW;  end
      S_RW:  state_nxt = S_I1;
      S_I1:  state_nxt = S_I2;
      S_I2:  state_nxt = S_I3;
      S_I3:  state_nxt = S_G1;
      S_G1:  state_nxt = S_G2;
      S_G2:  state_nxt = S_G3;
      S_G3:  state_nxt = S_UPD;
      S_UPD: state_nxt = S_FADE;
      S_FADE: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // words past the write point are only valid after the first wrap
    rd_ok = full_r || (rd_addr <= wr_idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      wr_idx_r      <= '0;
      full_r        <= 1'b0;
      ratio_valid_r <= 1'b0;
      smooth_r      <= '0;
      tap1_dly_r    <= '0;
      tap2_dly_r    <= '0;
      fade_phase_r  <= '0;
      fading_r      <= 1'b0;
    end else begin
      // output register loads when free or being drained, else drains on ready
      priority if (state_r == S_OUT && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready)                                           out_valid_r <= 1'b0;
      unique case (state_r)
        S_CHK: begin
          if (!pass && !ratio_valid_r) begin
            smooth_r      <= target_s[SMOOTH_W-1:0];
            ratio_valid_r <= 1'b1;
          end
        end
        S_SUPD: smooth_r <= smooth_new[SMOOTH_W-1:0];
        S_FADE: begin
          tap1_dly_r <= t1_clamp;
          tap2_dly_r <= t2_clamp;
          if (fade_end) begin
            fade_phase_r <= '0;
            fading_r     <= 1'b0;
          end else begin
            if (fade_on) fade_phase_r <= phase_sum[15:0];
            fading_r <= fade_on;
          end
          wr_idx_r <= wr_idx_r + 1'b1;
          if (&wr_idx_r) full_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        sample_r <= $signed(in_tdata[23:0]);
        if (in_tdata[38:24] < RATIO_MIN)      ratio_r <= RATIO_MIN;
        else if (in_tdata[38:24] > RATIO_MAX) ratio_r <= RATIO_MAX;
        else                                  ratio_r <= in_tdata[38:24];
      end
      S_CHK: res_r <= sample_r;
      S_RB1: a1_r <= rd_val;
      S_RA2: b1_r <= rd_val;
      S_RB2: a2_r <= rd_val;
      S_RW:  b2_r <= rd_val;
      S_I2:  tap1_r <= interp_tap;
      S_I3:  tap2_r <= interp_tap;
      S_G2:  acc_r <= mul_r;
      S_G3:  res_r <= mix_sat;
      S_UPD: begin
        t1n_r <= $signed({3'b0, tap1_dly_r}) + step16;
        t2n_r <= $signed({3'b0, tap2_dly_r}) + step16;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) out_data_r <= res_r;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fading_r |-> fade_phase_r == '0)
    else $error("fade phase nonzero outside a crossfade");

  a_taps_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FADE && min_delay_r <= max_delay_r) |=>
      (tap1_dly_r >= min_delay_r && tap1_dly_r <= max_delay_r &&
       tap2_dly_r >= min_delay_r && tap2_dly_r <= max_delay_r))
    else $error("tap delay outside its limits");

  a_wr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FADE |=> wr_idx_r == AW'($past(wr_idx_r) + 1'b1))
    else $error("write index did not advance by one");

  a_ratio_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ratio_valid_r |=> ratio_valid_r)
    else $error("ratio filter lost its seed");

endmodule
